// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file lhs_port_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- design/lhs_pkg.sv -----
// Types and constants of the line-of-sight horizon scanner.
// No dependencies.
`default_nettype none

package lhs_pkg;

   localparam int MAX_NODES_DEF = 65536;
   localparam int GRAD_W        = 32;
   localparam int DIST_W        = 32;
   localparam int IDX_OUT_W     = 16;
   localparam int CNT_OUT_W     = 17;

   localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [GRAD_W-1:0] node_gradient;
      logic [DIST_W-1:0]        node_distance;
      logic                     last_node;
   } lhs_req_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] max_gradient;
      logic [IDX_OUT_W-1:0]     max_gradient_index;
      logic signed [GRAD_W-1:0] max_gradient_before;
      logic [IDX_OUT_W-1:0]     max_before_index;
      logic [IDX_OUT_W-1:0]     horizon_index;
      logic [CNT_OUT_W-1:0]     horizon_count;
      logic [IDX_OUT_W-1:0]     horizon_before_index;
      logic [CNT_OUT_W-1:0]     horizon_before_count;
   } lhs_rsp_type;

   // Running maxima and latest horizon positions (counts kept apart,
   // their width follows the node limit).
   typedef struct packed {
      logic signed [GRAD_W-1:0] best_gradient;
      logic [IDX_OUT_W-1:0]     best_index;
      logic signed [GRAD_W-1:0] best_before_gradient;
      logic [IDX_OUT_W-1:0]     best_before_index;
      logic [IDX_OUT_W-1:0]     peak_index;
      logic [IDX_OUT_W-1:0]     peak_before_index;
   } lhs_track_type;

   localparam lhs_track_type TRACK_RESET = '{
      best_gradient:        GRAD_MIN,
      best_index:           '0,
      best_before_gradient: GRAD_MIN,
      best_before_index:    '0,
      peak_index:           '0,
      peak_before_index:    '0
   };

endpackage

`default_nettype wire

// ----- design/lhs_input_stage.sv -----
// Input register of the horizon scanner: one beat deep, refills each cycle while its beat is taken.
// Depends on lhs_pkg.
`default_nettype none

module lhs_input_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lhs_pkg::lhs_req_type req_data,
   input  wire logic                stage_take,
   output logic                     stage_valid,
   output lhs_pkg::lhs_req_type     stage_data
);

   logic                 valid_ff, valid_in;
   lhs_pkg::lhs_req_type data_ff, data_in;
   logic                 load;

   assign req_stall = valid_ff && !stage_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

`default_nettype wire

// ----- design/lhs_node_eval.sv -----
// Evaluates one node: horizon tests against earlier maxima, then max update.
// Depends on lhs_pkg.
`default_nettype none

module lhs_node_eval #(
   parameter int MAX_NODES = lhs_pkg::MAX_NODES_DEF,
   parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
   input  wire logic                                enable,
   input  wire logic                                has_next,
   input  wire logic [lhs_pkg::DIST_W-1:0]          target,
   input  wire logic [lhs_pkg::IDX_OUT_W-1:0]       idx,
   input  wire logic signed [lhs_pkg::GRAD_W-1:0]   grad,
   input  wire logic [lhs_pkg::DIST_W-1:0]          node_dist,
   input  wire logic signed [lhs_pkg::GRAD_W-1:0]   next_grad,
   input  wire logic [lhs_pkg::DIST_W-1:0]          next_dist,
   input  wire lhs_pkg::lhs_track_type              trk_cur,
   input  wire logic [CNT_W-1:0]                    cnt_cur,
   input  wire logic [CNT_W-1:0]                    cnt_before_cur,
   output lhs_pkg::lhs_track_type                   trk_nxt,
   output logic [CNT_W-1:0]                         cnt_nxt,
   output logic [CNT_W-1:0]                         cnt_before_nxt
);

   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_NODES);

   always_comb begin
      trk_nxt        = trk_cur;
      cnt_nxt        = cnt_cur;
      cnt_before_nxt = cnt_before_cur;
      if (enable) begin
         // horizon tests use maxima of earlier nodes only
         if (has_next && (next_grad < grad)) begin
            if ((next_dist <= target) && (trk_cur.best_before_gradient < grad)) begin
               trk_nxt.peak_before_index = idx;
               if (cnt_before_cur < CNT_SAT) begin
                  cnt_before_nxt = cnt_before_cur + CNT_W'(1);
               end
            end
            if (trk_cur.best_gradient < grad) begin
               trk_nxt.peak_index = idx;
               if (cnt_cur < CNT_SAT) begin
                  cnt_nxt = cnt_cur + CNT_W'(1);
               end
            end
         end
         if ((node_dist < target) && (trk_cur.best_before_gradient < grad)) begin
            trk_nxt.best_before_gradient = grad;
            trk_nxt.best_before_index    = idx;
         end
         if (trk_cur.best_gradient < grad) begin
            trk_nxt.best_gradient = grad;
            trk_nxt.best_index    = idx;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/lhs_scan_core.sv -----
// Scan state, held node, and result register of the horizon scanner.
// Depends on lhs_pkg and lhs_node_eval.
`default_nettype none

module lhs_scan_core #(
   parameter int MAX_NODES = lhs_pkg::MAX_NODES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [lhs_pkg::DIST_W-1:0]  target,
   input  wire logic                        stage_valid,
   input  wire lhs_pkg::lhs_req_type        stage_data,
   output logic                             stage_take,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output lhs_pkg::lhs_rsp_type             rsp_data
);

   localparam int IDX_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NODES - 1);

   logic [IDX_W-1:0]                     node_ctr_ff, node_ctr_in, ctr_after_held;
   logic                                 held_valid_ff, held_valid_in;
   logic signed [lhs_pkg::GRAD_W-1:0]    held_grad_ff, held_grad_in;
   logic [lhs_pkg::DIST_W-1:0]           held_dist_ff, held_dist_in;
   lhs_pkg::lhs_track_type               trk_ff, trk_in, trk_a, trk_b;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in, cnt_a, cnt_b;
   logic [CNT_W-1:0]                     cnt_bef_ff, cnt_bef_in, cnt_bef_a, cnt_bef_b;
   logic                                 rsp_valid_ff, rsp_valid_in;
   lhs_pkg::lhs_rsp_type                 rsp_data_ff, rsp_data_in;

   // a last node needs a free result slot; other nodes always proceed
   assign stage_take = stage_valid &&
                       !(stage_data.last_node && rsp_valid_ff && rsp_stall);

   assign ctr_after_held = !held_valid_ff       ? node_ctr_ff :
                           (node_ctr_ff == IDX_LAST) ? '0 :
                           node_ctr_ff + IDX_W'(1);

   // held node, judged against the new beat as its successor
   lhs_node_eval #(.MAX_NODES(MAX_NODES), .CNT_W(CNT_W)) u_eval_held (
      .enable         (held_valid_ff),
      .has_next       (1'b1),
      .target         (target),
      .idx            (lhs_pkg::IDX_OUT_W'(node_ctr_ff)),
      .grad           (held_grad_ff),
      .node_dist      (held_dist_ff),
      .next_grad      (stage_data.node_gradient),
      .next_dist      (stage_data.node_distance),
      .trk_cur        (trk_ff),
      .cnt_cur        (cnt_ff),
      .cnt_before_cur (cnt_bef_ff),
      .trk_nxt        (trk_a),
      .cnt_nxt        (cnt_a),
      .cnt_before_nxt (cnt_bef_a)
   );

   // last node of the line: no successor
   lhs_node_eval #(.MAX_NODES(MAX_NODES), .CNT_W(CNT_W)) u_eval_last (
      .enable         (1'b1),
      .has_next       (1'b0),
      .target         (target),
      .idx            (lhs_pkg::IDX_OUT_W'(ctr_after_held)),
      .grad           (stage_data.node_gradient),
      .node_dist      (stage_data.node_distance),
      .next_grad      (stage_data.node_gradient),
      .next_dist      (stage_data.node_distance),
      .trk_cur        (trk_a),
      .cnt_cur        (cnt_a),
      .cnt_before_cur (cnt_bef_a),
      .trk_nxt        (trk_b),
      .cnt_nxt        (cnt_b),
      .cnt_before_nxt (cnt_bef_b)
   );

   always_comb begin
      node_ctr_in   = node_ctr_ff;
      held_valid_in = held_valid_ff;
      held_grad_in  = held_grad_ff;
      held_dist_in  = held_dist_ff;
      trk_in        = trk_ff;
      cnt_in        = cnt_ff;
      cnt_bef_in    = cnt_bef_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (stage_take) begin
         if (!stage_data.last_node) begin
            node_ctr_in   = ctr_after_held;
            held_valid_in = 1'b1;
            held_grad_in  = stage_data.node_gradient;
            held_dist_in  = stage_data.node_distance;
            trk_in        = trk_a;
            cnt_in        = cnt_a;
            cnt_bef_in    = cnt_bef_a;
         end else begin
            node_ctr_in   = '0;
            held_valid_in = 1'b0;
            trk_in        = lhs_pkg::TRACK_RESET;
            cnt_in        = '0;
            cnt_bef_in    = '0;
            rsp_valid_in  = 1'b1;
            rsp_data_in.max_gradient         = trk_b.best_gradient;
            rsp_data_in.max_gradient_index   = trk_b.best_index;
            rsp_data_in.max_gradient_before  = trk_b.best_before_gradient;
            rsp_data_in.max_before_index     = trk_b.best_before_index;
            rsp_data_in.horizon_index        = trk_b.peak_index;
            rsp_data_in.horizon_count        = lhs_pkg::CNT_OUT_W'(cnt_b);
            rsp_data_in.horizon_before_index = trk_b.peak_before_index;
            rsp_data_in.horizon_before_count = lhs_pkg::CNT_OUT_W'(cnt_bef_b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ctr_ff   <= '0;
         held_valid_ff <= 1'b0;
         trk_ff        <= lhs_pkg::TRACK_RESET;
         cnt_ff        <= '0;
         cnt_bef_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_ctr_ff   <= node_ctr_in;
         held_valid_ff <= held_valid_in;
         trk_ff        <= trk_in;
         cnt_ff        <= cnt_in;
         cnt_bef_ff    <= cnt_bef_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_grad_ff <= held_grad_in;
      held_dist_ff <= held_dist_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/los_horizon_scanner_unit.sv -----
// A last-node beat passes the input register and then the result register before its summary shows on rsp_.
// Throughput: one node beat per cycle; the input stalls only when a last node finds
// the result register still full and stalled.
// Reset (synchronous, active high) clears the scan state, the held node, both
// valid flags and target_distance (to 0).
// Depends on lhs_pkg, lhs_input_stage, lhs_scan_core, lhs_node_eval.
`default_nettype none

module los_horizon_scanner_unit #(
   parameter int MAX_NODES = lhs_pkg::MAX_NODES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // node beats in
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire lhs_pkg::lhs_req_type        req_data,
   // summary beats out, one per line of sight
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output lhs_pkg::lhs_rsp_type             rsp_data,
   // target_distance register, write only
   input  wire logic                        csr_write_en,
   input  wire logic [lhs_pkg::DIST_W-1:0]  csr_write_data
);

   logic [lhs_pkg::DIST_W-1:0] target_ff, target_in;
   logic                       stage_valid;
   logic                       stage_take;
   lhs_pkg::lhs_req_type       stage_data;

   // Target distance, unsigned Q24.8. The user must write it only while idle; the block does not enforce this.
   assign target_in = csr_write_en ? csr_write_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   // Input register: decouples req_stall from the result side except when
   // a last node is blocked behind an untaken summary.
   lhs_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   // Core: the previous node is held back one beat so it can be compared
   // against its successor. On a last node both the held node and the last
   // node are folded in during the same cycle, the summary lands in the
   // result register, and the scan state returns to its reset values.
   lhs_scan_core #(.MAX_NODES(MAX_NODES)) u_core (
      .clock       (clock),
      .reset       (reset),
      .target      (target_ff),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/lhs_port_checker.sv -----
// Port-level checks for the horizon scanner, bound to the top level.
// Depends on lhs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lhs_port_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire lhs_pkg::lhs_rsp_type        rsp_data
);

   // a stalled summary stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // nodes before target are a subset of all nodes
   `ASSERT_IMPLIES(a_max_order, clock, reset, rsp_valid,
                   rsp_data.max_gradient_before <= rsp_data.max_gradient)

   // no horizon seen means no horizon position recorded
   `ASSERT_IMPLIES(a_no_horizon, clock, reset,
                   rsp_valid && (rsp_data.horizon_count == '0),
                   rsp_data.horizon_index == '0)

endmodule

bind los_horizon_scanner_unit lhs_port_checker u_port_checker (.*);

`default_nettype wire
